// File: rtl/core/tmq_pkg.sv
// Package for the tagged message queue unit.
// Holds the item kind and result status codes and the field widths; no dependencies.
package tmq_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;
  localparam logic [1:0] KIND_WIPE  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned TALLY_BITS  = 7;

endpackage

// File: rtl/core/tmq_if.sv
// Valid/ready channel interfaces for the tagged message queue unit.
// Depends on tmq_pkg for field widths.
interface tmq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic [tmq_pkg::TAG_BITS-1:0]         stream_tag;
  logic [tmq_pkg::HANDLE_BITS-1:0]      payload_handle;
  logic                                 error_flag;
  logic                                 marker_flag;

  modport source (output valid, kind, stream_tag, payload_handle, error_flag, marker_flag,
                  input ready);
  modport sink (input valid, kind, stream_tag, payload_handle, error_flag, marker_flag,
                output ready);
endinterface

interface tmq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic                                 found;
  logic [tmq_pkg::TAG_BITS-1:0]         got_tag;
  logic [tmq_pkg::HANDLE_BITS-1:0]      got_payload;
  logic                                 got_error;
  logic [tmq_pkg::TALLY_BITS-1:0]       tally;

  modport source (output valid, status, found, got_tag, got_payload, got_error, tally,
                  input ready);
  modport sink (input valid, status, found, got_tag, got_payload, got_error, tally,
                output ready);
endinterface

// File: rtl/core/tmq_store.sv
// Entry memory of the tagged message queue: one write port, one read port
// with registered read data. No dependencies.
module tmq_store #(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/tagged_message_queue_unit.sv
// Tagged message queue unit: ordered entry queue with get (first tag match, error or marker entry), count and wipe.
// Depends on tmq_pkg, tmq_in_if, tmq_out_if and tmq_store.
// Put goes straight to the finish state; get, count and wipe first read the occupied
// entries one per cycle in the scan state. The finish state registers the result once
// the output is free, and only then does the idle state take a new item.
// Asynchronous active-low reset empties the queue and clears the output.
module tagged_message_queue_unit #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmq_in_if.sink    in_i,
  tmq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (PAYLOAD_BITS > tmq_pkg::HANDLE_BITS) ?
                               PAYLOAD_BITS : tmq_pkg::HANDLE_BITS;
  localparam int unsigned XW = (CW > tmq_pkg::TALLY_BITS) ? CW : tmq_pkg::TALLY_BITS;

  typedef struct packed {
    logic [tmq_pkg::TAG_BITS-1:0] tag;
    logic [PAYLOAD_BITS-1:0]      payload;
    logic                         error;
    logic                         marker;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                       state_q;
  logic [CW-1:0]                occ_q;
  logic [CW-1:0]                rd_idx_q;
  logic [CW-1:0]                wr_idx_q;
  logic [CW-1:0]                n_q;
  logic                         pend_q;
  logic                         took_q;
  logic                         full_q;
  logic [1:0]                   kind_q;
  logic [tmq_pkg::TAG_BITS-1:0] tag_q;
  entry_t                       got_q;
  logic                         got_valid_q;

  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic                         out_found_q;
  logic [tmq_pkg::TAG_BITS-1:0] out_tag_q;
  logic [tmq_pkg::HANDLE_BITS-1:0] out_payload_q;
  logic                         out_error_q;
  logic [tmq_pkg::TALLY_BITS-1:0] out_tally_q;

  entry_t        rd_entry;
  entry_t        put_entry;
  entry_t        mem_wdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          in_xfer;
  logic          put_wr;
  logic          hit;
  logic          keep_wr;
  logic          issue;
  logic [PW-1:0] pay_in_ext;
  logic [PW-1:0] pay_out_ext;
  logic [CW-1:0] tally_val;
  logic [XW-1:0] tally_ext;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign pay_in_ext          = PW'(in_i.payload_handle);
  assign put_entry.tag       = in_i.stream_tag;
  assign put_entry.payload   = pay_in_ext[PAYLOAD_BITS-1:0];
  assign put_entry.error     = in_i.error_flag;
  assign put_entry.marker    = in_i.marker_flag;

  assign put_wr = in_xfer && (in_i.kind == tmq_pkg::KIND_PUT) && (occ_q < CW'(DEPTH));

  always_comb begin
    if (kind_q == tmq_pkg::KIND_GET) begin
      hit = !took_q && (rd_entry.marker || rd_entry.error || (rd_entry.tag == tag_q));
    end else begin
      hit = !rd_entry.marker && (rd_entry.tag == tag_q);
    end
  end

  assign keep_wr = (state_q == ST_SCAN) && pend_q && !hit && (kind_q != tmq_pkg::KIND_COUNT);
  assign issue   = (state_q == ST_SCAN) && (rd_idx_q < occ_q);

  always_comb begin
    if (state_q == ST_IDLE) begin
      mem_we    = put_wr;
      mem_waddr = occ_q[AW-1:0];
      mem_wdata = put_entry;
    end else begin
      mem_we    = keep_wr;
      mem_waddr = wr_idx_q[AW-1:0];
      mem_wdata = rd_entry;
    end
  end

  tmq_store #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  assign tally_val   = ((kind_q == tmq_pkg::KIND_COUNT) || (kind_q == tmq_pkg::KIND_WIPE)) ?
                       n_q : occ_q;
  assign tally_ext   = XW'(tally_val);
  assign pay_out_ext = PW'(got_q.payload);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      occ_q         <= '0;
      rd_idx_q      <= '0;
      wr_idx_q      <= '0;
      n_q           <= '0;
      pend_q        <= 1'b0;
      took_q        <= 1'b0;
      full_q        <= 1'b0;
      kind_q        <= tmq_pkg::KIND_PUT;
      tag_q         <= '0;
      got_q         <= '0;
      got_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      out_status_q  <= tmq_pkg::STATUS_OK;
      out_found_q   <= 1'b0;
      out_tag_q     <= '0;
      out_payload_q <= '0;
      out_error_q   <= 1'b0;
      out_tally_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            kind_q      <= in_i.kind;
            tag_q       <= in_i.stream_tag;
            rd_idx_q    <= '0;
            wr_idx_q    <= '0;
            n_q         <= '0;
            pend_q      <= 1'b0;
            took_q      <= 1'b0;
            got_valid_q <= 1'b0;
            got_q       <= '0;
            full_q      <= !put_wr;
            if (in_i.kind == tmq_pkg::KIND_PUT) begin
              if (put_wr) begin
                occ_q <= occ_q + CW'(1);
              end
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            rd_idx_q <= rd_idx_q + CW'(1);
          end
          if (pend_q) begin
            if (hit) begin
              n_q <= n_q + CW'(1);
              if (kind_q == tmq_pkg::KIND_GET) begin
                took_q <= 1'b1;
                if (!rd_entry.marker) begin
                  got_q       <= rd_entry;
                  got_valid_q <= 1'b1;
                end
              end
            end else if (kind_q != tmq_pkg::KIND_COUNT) begin
              wr_idx_q <= wr_idx_q + CW'(1);
            end
          end
          if (!pend_q && !issue) begin
            if (kind_q != tmq_pkg::KIND_COUNT) begin
              occ_q <= occ_q - n_q;
            end
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_found_q <= got_valid_q;
            out_tag_q   <= got_q.tag;
            out_payload_q <= pay_out_ext[tmq_pkg::HANDLE_BITS-1:0];
            out_error_q <= got_q.error;
            out_tally_q <= tally_ext[tmq_pkg::TALLY_BITS-1:0];
            if ((kind_q == tmq_pkg::KIND_PUT) && full_q) begin
              out_status_q <= tmq_pkg::STATUS_FULL;
            end else if ((kind_q == tmq_pkg::KIND_GET) && !took_q) begin
              out_status_q <= tmq_pkg::STATUS_EMPTY;
            end else begin
              out_status_q <= tmq_pkg::STATUS_OK;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found       = out_found_q;
  assign out_o.got_tag     = out_tag_q;
  assign out_o.got_payload = out_payload_q;
  assign out_o.got_error   = out_error_q;
  assign out_o.tally       = out_tally_q;

endmodule
